FILE: rtl/core/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg: shared types and constants of the priority interrupt controller
// Command codes, controller states and the control/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

	localparam int LINE_COUNT_DEFAULT = 64;
	localparam logic [7:0] IDLE_LEVEL = 8'hFF;

	typedef enum logic [2:0] {
		CMD_SET_PEND  = 3'd0,
		CMD_CLR_PEND  = 3'd1,
		CMD_ENABLE    = 3'd2,
		CMD_DISABLE   = 3'd3,
		CMD_SET_LEVEL = 3'd4,
		CMD_ACK       = 3'd5,
		CMD_COMPLETE  = 3'd6,
		CMD_QUERY     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_ACK,
		ST_REC_GO,
		ST_REC,
		ST_ARB_GO,
		ST_ARB,
		ST_RESULT
	} state_t;

	typedef enum logic {
		SCAN_ARB,
		SCAN_RECOMP
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       apply;
		logic       ack_take;
		logic       scan_go;
		scan_mode_t scan_mode;
	} ctl_t;

	typedef struct packed {
		logic ack_ok;
		logic complete;
		logic scan_done;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/core/priority_interrupt_controller.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller: vectored priority interrupt controller
// Applies one command per transaction to the line state, then arbitrates and
// reports the winning line and the running priority.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken on a clock edge with start high and busy low;
// busy then stays high until the result, which is on found/winner/
// running_level for the single cycle that done is high and is not held. Every
// line is examined once per scan through the single read port of the level
// memory, one line per cycle. An acknowledge adds one level fetch, and a
// complete runs a running-priority scan before the arbitration scan, so it
// examines every line twice. After reset every line reads as not pending,
// disabled, inactive and at level 0, with running priority 255; no clearing
// pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_interrupt_controller #(
	parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] line,
	input  wire logic [7:0] level,
	output logic            done,
	output logic            found,
	output logic [7:0]      winner,
	output logic [7:0]      running_level
);

	pic_pkg::ctl_t    ctl;
	pic_pkg::status_t status;

	pic_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	pic_datapath #(
		.LINE_COUNT (LINE_COUNT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.cmd           (cmd),
		.line          (line),
		.level         (level),
		.status        (status),
		.found         (found),
		.winner        (winner),
		.running_level (running_level)
	);

endmodule

`default_nettype wire

FILE: rtl/core/pic_ram.sv
// ----------------------------------------------------------------------------
// pic_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/pic_ctrl.sv
// ----------------------------------------------------------------------------
// pic_ctrl: command sequencer of the priority interrupt controller
// Steps each transaction through apply, optional level fetch or recompute
// scan, arbitration scan and the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire pic_pkg::status_t status,
	output pic_pkg::ctl_t         ctl,
	output logic                  busy,
	output logic                  done
);

	pic_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pic_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pic_pkg::ST_IDLE: begin
				if (start) state_d = pic_pkg::ST_APPLY;
			end
			pic_pkg::ST_APPLY: begin
				if (status.ack_ok)        state_d = pic_pkg::ST_ACK;
				else if (status.complete) state_d = pic_pkg::ST_REC_GO;
				else                      state_d = pic_pkg::ST_ARB_GO;
			end
			pic_pkg::ST_ACK:    state_d = pic_pkg::ST_ARB_GO;
			pic_pkg::ST_REC_GO: state_d = pic_pkg::ST_REC;
			pic_pkg::ST_REC: begin
				if (status.scan_done) state_d = pic_pkg::ST_ARB_GO;
			end
			pic_pkg::ST_ARB_GO: state_d = pic_pkg::ST_ARB;
			pic_pkg::ST_ARB: begin
				if (status.scan_done) state_d = pic_pkg::ST_RESULT;
			end
			pic_pkg::ST_RESULT: state_d = pic_pkg::ST_IDLE;
			default:            state_d = pic_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.scan_mode = pic_pkg::SCAN_ARB;
		case (state_q)
			pic_pkg::ST_IDLE:   ctl.load = start;
			pic_pkg::ST_APPLY:  ctl.apply = 1'b1;
			pic_pkg::ST_ACK:    ctl.ack_take = 1'b1;
			pic_pkg::ST_REC_GO: begin
				ctl.scan_go   = 1'b1;
				ctl.scan_mode = pic_pkg::SCAN_RECOMP;
			end
			pic_pkg::ST_REC:    ctl.scan_mode = pic_pkg::SCAN_RECOMP;
			pic_pkg::ST_ARB_GO: ctl.scan_go = 1'b1;
			default:            ctl = '0;
		endcase
	end

	assign busy = (state_q != pic_pkg::ST_IDLE);
	assign done = (state_q == pic_pkg::ST_RESULT);

	a_accept_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == pic_pkg::ST_APPLY)
		else $error("accepted transaction did not enter apply");

	a_arb_end_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pic_pkg::ST_ARB) && status.scan_done |=> done)
		else $error("arbitration finished without a result strobe");

endmodule

`default_nettype wire

FILE: rtl/core/pic_datapath.sv
// ----------------------------------------------------------------------------
// pic_datapath: line state, level memory and scan unit
// Holds the pending/enabled/active flags, the level memory with per-entry
// valid bits, the running priority and the one-compare-per-cycle scan that
// serves both the running-priority recompute and the arbitration.
// ----------------------------------------------------------------------------
`default_nettype none

module pic_datapath #(
	parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEFAULT,
	localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pic_pkg::ctl_t    ctl,
	input  wire logic [2:0]       cmd,
	input  wire logic [7:0]       line,
	input  wire logic [7:0]       level,
	output pic_pkg::status_t      status,
	output logic                  found,
	output logic [7:0]            winner,
	output logic [7:0]            running_level
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_COUNT - 1);

	// latched transaction
	pic_pkg::cmd_t cmd_q;
	logic [7:0]    line_q;
	logic [7:0]    level_q;

	logic [LINE_COUNT-1:0] pend_q, enab_q, act_q, lvl_valid_q;
	logic [7:0]            running_q;

	// scan unit
	logic                issuing_q;
	logic [IDX_W-1:0]    idx_q;
	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	pic_pkg::scan_mode_t mode_q;
	logic [7:0]          best_q;
	logic [7:0]          winner_q;
	logic                hit_q;

	logic             ok;
	logic [IDX_W-1:0] li;
	logic             ram_we;
	logic [IDX_W-1:0] raddr;
	logic [7:0]       rdata;
	logic [7:0]       scan_lvl;
	logic             scan_last;

	assign ok        = (line_q < 8'(LINE_COUNT));
	assign li        = line_q[IDX_W-1:0];
	assign ram_we    = ctl.apply && ok && (cmd_q == pic_pkg::CMD_SET_LEVEL);
	assign raddr     = issuing_q ? idx_q : li;
	assign scan_lvl  = lvl_valid_q[idx_s1] ? rdata : 8'd0;
	assign scan_last = v_s1 && (idx_s1 == LAST_IDX);

	pic_ram #(
		.WIDTH (8),
		.DEPTH (LINE_COUNT)
	) u_level_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (li),
		.wdata (level_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= pic_pkg::cmd_t'(cmd);
			line_q  <= line;
			level_q <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			enab_q      <= '0;
			act_q       <= '0;
			lvl_valid_q <= '0;
			running_q   <= pic_pkg::IDLE_LEVEL;
			issuing_q   <= 1'b0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			mode_q      <= pic_pkg::SCAN_ARB;
			best_q      <= pic_pkg::IDLE_LEVEL;
			winner_q    <= '0;
			hit_q       <= 1'b0;
		end else begin
			if (ctl.apply && ok) begin
				case (cmd_q)
					pic_pkg::CMD_SET_PEND:  pend_q[li] <= 1'b1;
					pic_pkg::CMD_CLR_PEND:  pend_q[li] <= 1'b0;
					pic_pkg::CMD_ENABLE:    enab_q[li] <= 1'b1;
					pic_pkg::CMD_DISABLE:   enab_q[li] <= 1'b0;
					pic_pkg::CMD_SET_LEVEL: lvl_valid_q[li] <= 1'b1;
					pic_pkg::CMD_ACK: begin
						pend_q[li] <= 1'b0;
						act_q[li]  <= 1'b1;
					end
					pic_pkg::CMD_COMPLETE:  act_q[li] <= 1'b0;
					default: ;
				endcase
			end

			// level fetched during apply arrives here
			if (ctl.ack_take) begin
				running_q <= lvl_valid_q[li] ? rdata : 8'd0;
			end

			// issue side of the scan
			if (ctl.scan_go) begin
				issuing_q <= 1'b1;
				idx_q     <= '0;
				mode_q    <= ctl.scan_mode;
				if (ctl.scan_mode == pic_pkg::SCAN_RECOMP) begin
					running_q <= pic_pkg::IDLE_LEVEL;
				end else begin
					best_q   <= running_q;
					winner_q <= '0;
					hit_q    <= 1'b0;
				end
			end else if (issuing_q) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == LAST_IDX) issuing_q <= 1'b0;
			end
			v_s1   <= issuing_q && !ctl.scan_go;
			idx_s1 <= idx_q;

			// compare side: one line per cycle
			if (v_s1) begin
				if (mode_q == pic_pkg::SCAN_RECOMP) begin
					if (act_q[idx_s1] && (scan_lvl < running_q)) running_q <= scan_lvl;
				end else begin
					if (pend_q[idx_s1] && enab_q[idx_s1] && (scan_lvl < best_q)) begin
						best_q   <= scan_lvl;
						winner_q <= 8'(idx_s1);
						hit_q    <= 1'b1;
					end
				end
			end
		end
	end

	assign status.ack_ok    = ok && (cmd_q == pic_pkg::CMD_ACK);
	assign status.complete  = (cmd_q == pic_pkg::CMD_COMPLETE);
	assign status.scan_done = scan_last;

	assign found         = hit_q;
	assign winner        = winner_q;
	assign running_level = running_q;

	a_go_when_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan_go |-> !issuing_q && !v_s1)
		else $error("scan restarted while a scan was running");

	a_stage_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> idx_s1 <= LAST_IDX)
		else $error("scan stage index beyond last line");

	a_winner_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> winner_q < 8'(LINE_COUNT))
		else $error("winner outside the line range");

endmodule

`default_nettype wire

FILE: tb/priority_interrupt_controller_checker.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller_checker: result checker
// Watches the command and result channels of the interrupt controller, keeps
// its own copy of the per-line state, predicts each outcome and compares the
// results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_interrupt_controller_checker #(
	parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       busy,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] line,
	input  wire logic [7:0] level,
	input  wire logic       done,
	input  wire logic       found,
	input  wire logic [7:0] winner,
	input  wire logic [7:0] running_level,
	output int              fail_count,
	output int              results_owed
);

	typedef struct packed {
		logic       found;
		logic [7:0] winner;
		logic [7:0] running_level;
	} irq_outcome_t;

	logic         pend_bit [LINE_COUNT];
	logic         enab_bit [LINE_COUNT];
	logic         actv_bit [LINE_COUNT];
	logic [7:0]   line_lvl [LINE_COUNT];
	logic [7:0]   run_lvl;
	irq_outcome_t outcome_q [$];
	int           result_count;

	task automatic report_mismatch(input string what);
		$display("MISMATCH result %0d: %s", result_count, what);
		fail_count++;
	endtask

	function automatic irq_outcome_t arbitrate();
		irq_outcome_t res;
		logic [7:0]   best;
		res.found = 1'b0;
		res.winner = 8'd0;
		best = run_lvl;
		// strict compare: on equal levels the lower index keeps the win
		for (int i = 0; i < LINE_COUNT; i++) begin
			if (pend_bit[i] && enab_bit[i] && line_lvl[i] < best) begin
				best = line_lvl[i];
				res.winner = 8'(i);
				res.found = 1'b1;
			end
		end
		res.running_level = run_lvl;
		return res;
	endfunction

	task automatic apply_command(input pic_pkg::cmd_t op, input logic [7:0] ln,
			input logic [7:0] lv);
		logic       in_range;
		logic [7:0] lowest;
		in_range = (ln < LINE_COUNT);
		case (op)
			pic_pkg::CMD_SET_PEND:  if (in_range) pend_bit[ln] = 1'b1;
			pic_pkg::CMD_CLR_PEND:  if (in_range) pend_bit[ln] = 1'b0;
			pic_pkg::CMD_ENABLE:    if (in_range) enab_bit[ln] = 1'b1;
			pic_pkg::CMD_DISABLE:   if (in_range) enab_bit[ln] = 1'b0;
			pic_pkg::CMD_SET_LEVEL: if (in_range) line_lvl[ln] = lv;
			pic_pkg::CMD_ACK: if (in_range) begin
				pend_bit[ln] = 1'b0;
				actv_bit[ln] = 1'b1;
				run_lvl = line_lvl[ln];
			end
			pic_pkg::CMD_COMPLETE: begin
				// recompute even when the line is out of range
				if (in_range)
					actv_bit[ln] = 1'b0;
				lowest = pic_pkg::IDLE_LEVEL;
				for (int i = 0; i < LINE_COUNT; i++)
					if (actv_bit[i] && line_lvl[i] < lowest)
						lowest = line_lvl[i];
				run_lvl = lowest;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		irq_outcome_t exp_o;
		if (!arst_n) begin
			for (int i = 0; i < LINE_COUNT; i++) begin
				pend_bit[i] = 1'b0;
				enab_bit[i] = 1'b0;
				actv_bit[i] = 1'b0;
				line_lvl[i] = 8'd0;
			end
			run_lvl = pic_pkg::IDLE_LEVEL;
			outcome_q.delete();
			results_owed = 0;
		end else begin
			// retire the result before taking a new transaction on the same edge
			if (done) begin
				if (outcome_q.size() == 0) begin
					report_mismatch("result with no transaction waiting");
				end else begin
					exp_o = outcome_q.pop_front();
					if (found !== exp_o.found)
						report_mismatch($sformatf("found %b, expected %b",
							found, exp_o.found));
					if (winner !== exp_o.winner)
						report_mismatch($sformatf("winner %0d, expected %0d",
							winner, exp_o.winner));
					if (running_level !== exp_o.running_level)
						report_mismatch($sformatf("running_level %0d, expected %0d",
							running_level, exp_o.running_level));
				end
				result_count++;
			end
			if (start && !busy) begin
				apply_command(pic_pkg::cmd_t'(cmd), line, level);
				outcome_q.push_back(arbitrate());
			end
			results_owed = outcome_q.size();
		end
	end

endmodule

FILE: tb/priority_interrupt_controller_test.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller_test: testbench top
// Drives directed and random interrupt commands into the controller with
// random gaps and pauses, lets the checker predict and compare every result,
// and reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module priority_interrupt_controller_test;

	localparam int LINE_COUNT     = pic_pkg::LINE_COUNT_DEFAULT;
	localparam int RANDOM_ITEMS   = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * LINE_COUNT + 16;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [2:0] cmd;
	logic [7:0] line;
	logic [7:0] level;
	logic       done;
	logic       found;
	logic [7:0] winner;
	logic [7:0] running_level;

	int         fail_count;
	int         results_owed;
	int         quiet_cycles = 0;
	logic       last_found = 1'b0;
	logic [7:0] last_winner = 8'd0;
	logic       acked_line [LINE_COUNT];

	priority_interrupt_controller #(
		.LINE_COUNT(LINE_COUNT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.line(line),
		.level(level),
		.done(done),
		.found(found),
		.winner(winner),
		.running_level(running_level)
	);

	priority_interrupt_controller_checker #(
		.LINE_COUNT(LINE_COUNT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.line(line),
		.level(level),
		.done(done),
		.found(found),
		.winner(winner),
		.running_level(running_level),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles with no transaction and no result; also track the
	// last winner so acknowledges can follow the arbitration
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[priority_interrupt_controller] ERROR");
			$finish;
		end
		if (done) begin
			last_found <= found;
			last_winner <= winner;
		end
	end

	task automatic issue(input pic_pkg::cmd_t op, input logic [7:0] ln,
			input logic [7:0] lv);
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		line <= ln;
		level <= lv;
		// busy only moves on the rising edge, so it is stable here
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic stay_quiet(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= 3'($urandom_range(0, 7));
			line <= 8'($urandom_range(0, 255));
			level <= 8'($urandom_range(0, 255));
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		start <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
	endtask

	function automatic logic [7:0] pick_line();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return 8'($urandom_range(LINE_COUNT, 255));
		else if (r < 60)
			return 8'($urandom_range(0, 7));
		else
			return 8'($urandom_range(0, LINE_COUNT - 1));
	endfunction

	function automatic logic [7:0] pick_acked_line();
		int base;
		int idx;
		base = $urandom_range(0, LINE_COUNT - 1);
		for (int i = 0; i < LINE_COUNT; i++) begin
			idx = (base + i) % LINE_COUNT;
			if (acked_line[idx])
				return 8'(idx);
		end
		return pick_line();
	endfunction

	task automatic random_command();
		int            r;
		pic_pkg::cmd_t op;
		logic [7:0]    ln;
		logic [7:0]    lv;
		r = $urandom_range(0, 99);
		ln = pick_line();
		lv = 8'($urandom_range(0, 255));
		if (r < 18)      op = pic_pkg::CMD_SET_PEND;
		else if (r < 24) op = pic_pkg::CMD_CLR_PEND;
		else if (r < 36) op = pic_pkg::CMD_ENABLE;
		else if (r < 41) op = pic_pkg::CMD_DISABLE;
		else if (r < 55) op = pic_pkg::CMD_SET_LEVEL;
		else if (r < 70) op = pic_pkg::CMD_ACK;
		else if (r < 88) op = pic_pkg::CMD_COMPLETE;
		else             op = pic_pkg::CMD_QUERY;
		case (op)
			pic_pkg::CMD_SET_LEVEL: begin
				// favor low levels so ties and nesting occur often
				if ($urandom_range(0, 1) == 0)
					lv = 8'($urandom_range(0, 15));
			end
			pic_pkg::CMD_ACK: begin
				if (last_found && $urandom_range(0, 99) < 70)
					ln = last_winner;
				if (ln < LINE_COUNT)
					acked_line[ln] = 1'b1;
			end
			pic_pkg::CMD_COMPLETE: begin
				if ($urandom_range(0, 99) < 70)
					ln = pick_acked_line();
				if (ln < LINE_COUNT)
					acked_line[ln] = 1'b0;
			end
			default: ;
		endcase
		issue(op, ln, lv);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = pic_pkg::CMD_QUERY;
		line = 8'd0;
		level = 8'd0;
		for (int i = 0; i < LINE_COUNT; i++)
			acked_line[i] = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ties, out-of-range lines, nesting and completion order
		issue(pic_pkg::CMD_QUERY, 8'd0, 8'd0);
		issue(pic_pkg::CMD_SET_LEVEL, 8'd63, 8'd255);
		issue(pic_pkg::CMD_SET_LEVEL, 8'd5, 8'd10);
		issue(pic_pkg::CMD_SET_LEVEL, 8'd3, 8'd10);
		issue(pic_pkg::CMD_SET_PEND, 8'd5, 8'd0);
		issue(pic_pkg::CMD_ENABLE, 8'd5, 8'd0);
		issue(pic_pkg::CMD_SET_PEND, 8'd3, 8'd0);
		issue(pic_pkg::CMD_ENABLE, 8'd3, 8'd0);
		issue(pic_pkg::CMD_SET_PEND, 8'd255, 8'd255);
		issue(pic_pkg::CMD_ENABLE, 8'(LINE_COUNT), 8'd0);
		issue(pic_pkg::CMD_ACK, 8'd3, 8'd0);
		issue(pic_pkg::CMD_SET_LEVEL, 8'd3, 8'd200);
		issue(pic_pkg::CMD_SET_LEVEL, 8'd7, 8'd0);
		issue(pic_pkg::CMD_SET_PEND, 8'd7, 8'd0);
		issue(pic_pkg::CMD_ENABLE, 8'd7, 8'd0);
		issue(pic_pkg::CMD_ACK, 8'd7, 8'd0);
		issue(pic_pkg::CMD_ACK, 8'd5, 8'd0);
		issue(pic_pkg::CMD_COMPLETE, 8'd200, 8'd0);
		issue(pic_pkg::CMD_COMPLETE, 8'd7, 8'd0);
		issue(pic_pkg::CMD_COMPLETE, 8'd5, 8'd0);
		issue(pic_pkg::CMD_COMPLETE, 8'd3, 8'd0);
		issue(pic_pkg::CMD_SET_PEND, 8'd63, 8'd0);
		issue(pic_pkg::CMD_ENABLE, 8'd63, 8'd0);
		issue(pic_pkg::CMD_DISABLE, 8'd63, 8'd0);
		issue(pic_pkg::CMD_CLR_PEND, 8'd63, 8'd0);
		issue(pic_pkg::CMD_QUERY, 8'd255, 8'd255);

		// hold off until the directed results are all in
		wait_for_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// no gaps and no pauses in the middle stretch
			if (n < 150 || n >= 250) begin
				if ($urandom_range(0, 99) < 12)
					stay_quiet($urandom_range(1, 3));
				if ($urandom_range(0, 99) < 2)
					wait_for_results();
			end
			random_command();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[priority_interrupt_controller] OK");
		else
			$display("[priority_interrupt_controller] ERROR");
		$finish;
	end

endmodule
